### hdl/cartridge_bank_mapper_top_macros.svh
// Assertion macros for the cartridge bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_TOP_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define CBM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("cartridge bank mapper: implication check failed");
// Next-cycle implication, checked outside reset.
`define CBM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("cartridge bank mapper: next-cycle check failed");
`else
`define CBM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CBM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/cbm_pkg.sv
// Types and constants shared by the cartridge bank mapper.
`timescale 1ns / 1ps

package cbm_pkg;

	localparam int PATTERN_SLOTS = 8;
	localparam int PROGRAM_SLOTS = 4;

	localparam int PAT_IDX_W  = $clog2(PATTERN_SLOTS);
	localparam int PRG_IDX_W  = $clog2(PROGRAM_SLOTS);
	localparam int PAT_BANK_W = 8;
	localparam int PRG_BANK_W = 6;
	localparam int SIZE_W     = 6;
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int MAP_W      = 19;
	localparam int DIVISOR_W  = 9;
	localparam int DIV_STEPS  = DATA_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// Item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_PAT   = 2'd1;
	localparam logic [1:0] KIND_PRG   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_CHR_SIZE = 2'd0;
	localparam logic [1:0] CFG_PRG_SIZE = 2'd1;

	// Mapper register addresses
	localparam logic [ADDR_W-1:0] REG_PAIR_LO  = 16'h7EF0;
	localparam logic [ADDR_W-1:0] REG_PAIR_HI  = 16'h7EF1;
	localparam logic [ADDR_W-1:0] REG_ONE_LO   = 16'h7EF2;
	localparam logic [ADDR_W-1:0] REG_ONE_HI   = 16'h7EF5;
	localparam logic [ADDR_W-1:0] REG_CTRL     = 16'h7EF6;
	localparam logic [ADDR_W-1:0] REG_PRG_LO   = 16'h7EFA;
	localparam logic [ADDR_W-1:0] REG_PRG_HI   = 16'h7EFC;

	localparam logic [SIZE_W-1:0] CHR_SIZE_RST = 6'd16;
	localparam logic [SIZE_W-1:0] PRG_SIZE_RST = 6'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_APPLY
	} state_t;

	typedef enum logic [1:0] {
		TGT_PAIR,
		TGT_ONE,
		TGT_PRG
	} target_t;

	typedef logic [PROGRAM_SLOTS-1:0][PRG_BANK_W-1:0] prg_banks_t;

	// Program banks after reset or a size change: 0, 1, last-1, last.
	function automatic prg_banks_t prg_reload(input logic [SIZE_W-1:0] size);
		logic [PRG_BANK_W-1:0] last;
		prg_banks_t b;
		last = {size[SIZE_W-2:0], 1'b0} - PRG_BANK_W'(1);
		b[0] = PRG_BANK_W'(0);
		b[1] = PRG_BANK_W'(1);
		b[2] = last - PRG_BANK_W'(1);
		b[3] = last;
		return b;
	endfunction

endpackage

### hdl/cartridge_bank_mapper_top.sv
// Cartridge bank mapper: register decode, bank store, shared remainder unit.
// Fetches and writes that need no reduction: one word in, result registered
// the next cycle, one word per cycle while the output is drained.
// Bank writes: accept, 8 remainder steps, bank update; no new word is taken until
// the update lands. The remainder unit is restoring and takes one bit per step.
// Reset (arst_n low, asynchronous): banks to power-on pages, sizes 16 and 8.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_top_macros.svh"

module cartridge_bank_mapper_top
	import cbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // address[15:0], wdata[23:16]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // mapped_address[18:0], mirror_mode[19], zero[23:20]
	output logic        m_axis_tuser,  // mapped_valid[0]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	// Unpack the input word.
	logic [1:0]        kind;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] wdata;
	assign kind  = s_axis_tuser;
	assign addr  = s_axis_tdata[ADDR_W-1:0];
	assign wdata = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];

	// Mapper state.
	logic [SIZE_W-1:0]     chr_size_q;
	logic [SIZE_W-1:0]     prg_size_q;
	logic [PAT_BANK_W-1:0] pat_bank_q [PATTERN_SLOTS];
	prg_banks_t            prg_bank_q;
	logic                  swap_q;
	logic                  mirror_q;

	// Sequencer and remainder unit.
	state_t                state_q, state_nxt;
	logic [STEP_W-1:0]     step_q;
	logic [DATA_W-1:0]     dvd_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W-1:0]  rem_q;
	target_t               tgt_q;
	logic [PAT_IDX_W-1:0]  slot_q;
	logic [PRG_IDX_W-1:0]  prg_slot_q;

	logic accept, out_free, div_run, apply_en, div_last;

	// Hold configuration writes until a pending bank update has landed.
	assign cfg_ready = state_q == ST_IDLE;
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign div_last  = state_q == ST_DIV && step_q == STEP_W'(DIV_STEPS - 1);

	// Decode of the word being offered.
	logic chr_on, is_write, is_pair, is_one, is_ctrl, is_prg, need_div;
	assign chr_on   = chr_size_q != '0;
	assign is_write = kind == KIND_WRITE;
	assign is_pair  = is_write && chr_on && (addr == REG_PAIR_LO || addr == REG_PAIR_HI);
	assign is_one   = is_write && chr_on && addr >= REG_ONE_LO && addr <= REG_ONE_HI;
	assign is_ctrl  = is_write && addr == REG_CTRL;
	assign is_prg   = is_write && addr >= REG_PRG_LO && addr <= REG_PRG_HI;
	assign need_div = is_pair || is_one || is_prg;

	logic [PAT_IDX_W-1:0] half;
	assign half = swap_q ? PAT_IDX_W'(PATTERN_SLOTS / 2) : '0;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && need_div) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_APPLY;
			end
			ST_APPLY: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		div_run       = 1'b0;
		apply_en      = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_axis_tready = out_free;
			ST_DIV:   div_run = 1'b1;
			ST_APPLY: apply_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// One restoring remainder step: shift in the next dividend bit, subtract if it fits.
	// A zero divisor always subtracts nothing, which leaves the dividend itself.
	logic [DIVISOR_W:0] trial;
	logic               fits;
	assign trial = {rem_q, dvd_q[DATA_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (accept && need_div) begin
			rem_q <= '0;
			tgt_q <= is_prg ? TGT_PRG : (is_pair ? TGT_PAIR : TGT_ONE);
			if (is_prg) begin
				dvd_q <= {2'b00, wdata[DATA_W-1:2]};
				dvs_q <= {2'b00, prg_size_q, 1'b0};
			end else begin
				dvd_q <= is_pair ? {wdata[DATA_W-1:1], 1'b0} : wdata;
				dvs_q <= {chr_size_q, 3'b000};
			end
			// pair: half + 2*(addr - first); single: (4 - half) + (addr - first)
			if (is_pair) begin
				slot_q <= half + {1'b0, addr[0], 1'b0};
			end else begin
				slot_q <= (PAT_IDX_W'(PATTERN_SLOTS / 2) - half)
					+ (addr[PAT_IDX_W-1:0] - REG_ONE_LO[PAT_IDX_W-1:0]);
			end
			prg_slot_q <= addr[PRG_IDX_W-1:0] - REG_PRG_LO[PRG_IDX_W-1:0];
		end else if (div_run) begin
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (div_run) begin
			step_q <= step_q + STEP_W'(1);
		end else begin
			step_q <= '0;
		end
	end

	// Bank store, control bits and sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_size_q <= CHR_SIZE_RST;
			prg_size_q <= PRG_SIZE_RST;
			for (int i = 0; i < PATTERN_SLOTS; i++) begin
				pat_bank_q[i] <= PAT_BANK_W'(i);
			end
			prg_bank_q <= prg_reload(PRG_SIZE_RST);
			swap_q     <= 1'b0;
			mirror_q   <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CHR_SIZE: chr_size_q <= cfg_data;
					CFG_PRG_SIZE: begin
						prg_size_q <= cfg_data;
						prg_bank_q <= prg_reload(cfg_data);
					end
					default: ;
				endcase
			end
			if (accept && is_ctrl) begin
				swap_q   <= wdata[1];
				mirror_q <= wdata[0];
			end
			if (apply_en) begin
				case (tgt_q)
					TGT_PAIR: begin
						pat_bank_q[slot_q] <= rem_q[PAT_BANK_W-1:0];
						pat_bank_q[slot_q + PAT_IDX_W'(1)] <=
							rem_q[PAT_BANK_W-1:0] + PAT_BANK_W'(1);
					end
					TGT_ONE: pat_bank_q[slot_q] <= rem_q[PAT_BANK_W-1:0];
					TGT_PRG: prg_bank_q[prg_slot_q] <= rem_q[PRG_BANK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Translate a fetch; writes give zero and the mirroring bit after the write.
	logic [MAP_W-1:0] map_addr;
	logic             map_ok;
	logic             mirror_nxt;

	always_comb begin
		map_addr = '0;
		map_ok   = 1'b0;
		case (kind)
			KIND_PAT: begin
				if (chr_on && addr[ADDR_W-1:13] == '0) begin
					map_addr = {1'b0, pat_bank_q[addr[12:10]], addr[9:0]};
					map_ok   = 1'b1;
				end
			end
			KIND_PRG: begin
				if (addr[ADDR_W-1]) begin
					map_addr = {prg_bank_q[addr[14:13]], addr[12:0]};
					map_ok   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign mirror_nxt = is_ctrl ? wdata[0] : mirror_q;

	// Result register: load on accept, hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (accept) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_axis_tdata <= {4'b0000, mirror_nxt, map_addr};
			m_axis_tuser <= map_ok;
		end
	end

	// Checks on the sequencer and the remainder unit.
	`CBM_ASSERT_NXT(a_div_start, clk, arst_n, accept && need_div, div_run && !s_axis_tready)
	`CBM_ASSERT_NXT(a_div_end, clk, arst_n, div_last, state_q == ST_APPLY)
	`CBM_ASSERT_IMP(a_rem_range, clk, arst_n, state_q == ST_DIV && dvs_q != '0, rem_q < dvs_q)

endmodule

### bench/cartridge_bank_mapper_checker.sv
// Checker for the cartridge bank mapper: predicts each result word and compares it.
`timescale 1ns / 1ps

module cartridge_bank_mapper_checker
	import cbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // address[15:0], wdata[23:16]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,  // mapped_address[18:0], mirror_mode[19], zero[23:20]
	input  logic        m_axis_tuser,  // mapped_valid[0]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [MAP_W-1:0] rom_offset;
		logic             hit;
		logic             mirror;
	} fetch_result_t;

	localparam logic [ADDR_W-1:0] PPU_WINDOW_END = 16'h2000;

	logic [PAT_BANK_W-1:0] pat_page [PATTERN_SLOTS];
	logic [PRG_BANK_W-1:0] prg_page [PROGRAM_SLOTS];
	logic                  swap_halves;
	logic                  mirror_flag;
	logic [SIZE_W-1:0]     chr_units;
	logic [SIZE_W-1:0]     prg_units;
	fetch_result_t         expected_results [$];

	function automatic void reload_program_pages();
		logic [PRG_BANK_W-1:0] last;
		last = PRG_BANK_W'(prg_units * 2 - 1);
		prg_page[0] = PRG_BANK_W'(0);
		prg_page[1] = PRG_BANK_W'(1);
		prg_page[2] = last - PRG_BANK_W'(1);
		prg_page[3] = last;
	endfunction

	function automatic void apply_register_write(input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		int unsigned half;
		int unsigned slot;
		int unsigned v;
		int unsigned m;
		half = swap_halves ? 4 : 0;
		if (a >= REG_PAIR_LO && a <= REG_ONE_HI) begin
			// no pattern ROM: pattern bank writes fall on the floor
			if (chr_units != 0) begin
				m = chr_units * 8;
				if (a <= REG_PAIR_HI) begin
					slot = (half + (a - REG_PAIR_LO) * 2) & 7;
					v = (int'(d & 8'hFE) % m) & 8'hFF;
					pat_page[PAT_IDX_W'(slot)] = v[7:0];
					pat_page[PAT_IDX_W'(slot + 1)] = v[7:0] + 8'd1;
				end else begin
					slot = ((4 - half) + (a - REG_ONE_LO)) & 7;
					v = (int'(d) % m) & 8'hFF;
					pat_page[PAT_IDX_W'(slot)] = v[7:0];
				end
			end
		end else if (a == REG_CTRL) begin
			swap_halves = d[1];
			mirror_flag = d[0];
		end else if (a >= REG_PRG_LO && a <= REG_PRG_HI) begin
			v = int'(d) >> 2;
			m = prg_units * 2;
			// zero program size stores the shifted byte unreduced
			if (m != 0)
				v = v % m;
			prg_page[PRG_IDX_W'(a - REG_PRG_LO)] = v[PRG_BANK_W-1:0];
		end
	endfunction

	function automatic fetch_result_t translate_word(input logic [1:0] kind,
			input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		fetch_result_t r;
		r = '0;
		case (kind)
			KIND_WRITE: apply_register_write(a, d);
			KIND_PAT: begin
				if (chr_units != 0 && a < PPU_WINDOW_END) begin
					r.rom_offset = {1'b0, pat_page[a[12:10]], a[9:0]};
					r.hit = 1'b1;
				end
			end
			KIND_PRG: begin
				if (a[15]) begin
					r.rom_offset = {prg_page[a[14:13]], a[12:0]};
					r.hit = 1'b1;
				end
			end
			default: ;
		endcase
		r.mirror = mirror_flag;
		return r;
	endfunction

	function automatic void flag_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		errors++;
		$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fetch_result_t want;
		if (!arst_n) begin
			chr_units = CHR_SIZE_RST;
			prg_units = PRG_SIZE_RST;
			for (int i = 0; i < PATTERN_SLOTS; i++)
				pat_page[i] = PAT_BANK_W'(i);
			reload_program_pages();
			swap_halves = 1'b0;
			mirror_flag = 1'b1;
			expected_results.delete();
			errors = 0;
		end else begin
			// results first: a word accepted at this edge belongs to an older item
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word: expected none, actual %h/%b",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata[18:0] !== want.rom_offset)
						flag_mismatch("mapped_address", want.rom_offset, m_axis_tdata[18:0]);
					if (m_axis_tuser !== want.hit)
						flag_mismatch("mapped_valid", want.hit, m_axis_tuser);
					if (m_axis_tdata[19] !== want.mirror)
						flag_mismatch("mirror_mode", want.mirror, m_axis_tdata[19]);
					if (m_axis_tdata[23:20] !== 4'd0)
						flag_mismatch("tdata padding", 0, m_axis_tdata[23:20]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CHR_SIZE) begin
					chr_units = cfg_data;
				end else if (cfg_index == CFG_PRG_SIZE) begin
					prg_units = cfg_data;
					reload_program_pages();
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(translate_word(s_axis_tuser,
					s_axis_tdata[15:0], s_axis_tdata[23:16]));
		end
		pending = expected_results.size();
	end

endmodule

### bench/cartridge_bank_mapper_top_tb.sv
// Testbench top for the cartridge bank mapper: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module cartridge_bank_mapper_top_tb;
	import cbm_pkg::*;

	// kind 3 is not decoded by the block; it must pass through as a null word
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// result side holds off this long once per run to back the block up
	localparam int LONG_HOLD = 400;
	// cycles with no handshake on any channel before the run is declared hung
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS = 230;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // address[15:0], wdata[23:16]
	logic [1:0]  s_axis_tuser;   // kind[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // mapped_address[18:0], mirror_mode[19], zero[23:20]
	logic        m_axis_tuser;   // mapped_valid[0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;

	int errors;
	int pending;
	int idle_cycles;
	// when set, both sides run without gaps
	bit steady;
	int holds_requested;
	int holds_done;

	cartridge_bank_mapper_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	cartridge_bank_mapper_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		return steady ? 0 : $urandom_range(0, 18);
	endfunction

	// Offer one input word after a random gap and hold it until it is taken.
	// Valid stays high across back-to-back words so it never toggles within a step.
	task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
			input logic [7:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {data, addr};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted word has come back.
	// Always steps the clock before checking, so a following raise of valid is a new step.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [5:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Change ROM sizes only with the block idle.
	task automatic set_sizes(input logic [5:0] chr, input logic [5:0] prg);
		wait_drained();
		cfg_write(CFG_CHR_SIZE, chr);
		cfg_write(CFG_PRG_SIZE, prg);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly well-formed traffic: register writes around the mapper window,
	// pattern fetches below 0x2000, program fetches above 0x8000; a slice of noise.
	task automatic send_random_item();
		int unsigned pick;
		logic [1:0]  kind;
		logic [15:0] addr;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			kind = KIND_WRITE;
			addr = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16'hFFFF))
				: REG_PAIR_LO + 16'($urandom_range(0, 13));
		end else if (pick < 60) begin
			kind = KIND_PAT;
			addr = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 16'hFFFF))
				: 16'($urandom_range(0, 16'h1FFF));
		end else if (pick < 95) begin
			kind = KIND_PRG;
			addr = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 16'hFFFF))
				: 16'($urandom_range(16'h8000, 16'hFFFF));
		end else begin
			kind = KIND_UNUSED;
			addr = 16'($urandom_range(0, 16'hFFFF));
		end
		send_item(kind, addr, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_run(input int count);
		for (int i = 0; i < count; i++) begin
			// alternate gap-free stretches with randomly idled ones
			if (i % 64 == 0)
				steady = ($urandom_range(0, 3) == 0);
			send_random_item();
		end
		steady = 1'b0;
	endtask

	// Result side: random stalls per word, plus the one long hold-off on request.
	initial begin
		int unsigned stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (holds_done < holds_requested) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				stall = pick_gap();
				if (stall != 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// Watchdog: count cycles in which no channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = '0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		steady          = 1'b0;
		holds_requested = 0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at the power-on sizes (16 pattern units, 8 program units).
		send_item(KIND_PAT, 16'h0000, 8'h00);
		send_item(KIND_PAT, 16'h1FFF, 8'hFF);
		send_item(KIND_PAT, 16'h2000, 8'h00);       // just past the pattern window
		send_item(KIND_PAT, 16'hFFFF, 8'hFF);
		send_item(KIND_PRG, 16'h7FFF, 8'h00);       // just below the program window
		send_item(KIND_PRG, 16'h8000, 8'h00);
		send_item(KIND_PRG, 16'hFFFF, 8'hFF);       // fixed last bank
		send_item(KIND_WRITE, REG_PAIR_LO, 8'hFF);  // low bit cleared, then reduced
		send_item(KIND_WRITE, REG_PAIR_HI, 8'h00);
		send_item(KIND_WRITE, REG_ONE_LO, 8'hFF);
		send_item(KIND_WRITE, REG_ONE_HI, 8'h80);
		send_item(KIND_WRITE, REG_CTRL, 8'h03);     // swap halves, mirror set
		send_item(KIND_WRITE, REG_PAIR_LO, 8'h12);  // pair now lands in the upper half
		send_item(KIND_WRITE, REG_ONE_LO + 16'd1, 8'h7F);
		send_item(KIND_PAT, 16'h0400, 8'h00);
		send_item(KIND_PAT, 16'h1800, 8'h00);
		send_item(KIND_WRITE, REG_PRG_LO, 8'hFF);
		send_item(KIND_WRITE, REG_PRG_LO + 16'd1, 8'h00);
		send_item(KIND_WRITE, REG_PRG_HI, 8'h40);
		send_item(KIND_PRG, 16'hA000, 8'h00);
		send_item(KIND_PRG, 16'hDFFF, 8'h00);
		send_item(KIND_WRITE, REG_CTRL + 16'd1, 8'hFF);  // hole in the register map
		send_item(KIND_WRITE, 16'hFFFF, 8'hAA);          // far outside the map
		send_item(KIND_UNUSED, 16'h8000, 8'hFF);
		send_item(KIND_WRITE, REG_CTRL, 8'h00);

		// Back-pressure: hold off results for a long stretch while words keep
		// coming gap-free, then pause input until everything has drained.
		holds_requested++;
		steady = 1'b1;
		for (int i = 0; i < 40; i++)
			send_random_item();
		steady = 1'b0;
		wait_drained();
		send_random_run(PHASE_WORDS);

		// Sweep ROM sizes, extremes and oversized values included.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: set_sizes(6'd0, 6'd1);    // no pattern ROM, smallest program ROM
				1: set_sizes(6'd32, 6'd32);
				2: set_sizes(6'd3, 6'd5);
				3: set_sizes(6'd63, 6'd0);   // oversized pattern, zero program size
				4: set_sizes(6'd1, 6'd2);
				5: set_sizes(6'd7, 6'd63);
				default: set_sizes(CHR_SIZE_RST, PRG_SIZE_RST);
			endcase
			send_random_run(PHASE_WORDS);
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
